// ----- src/bpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_T1    = 3'd0;
   localparam logic [2:0] REG_T2    = 3'd1;
   localparam logic [2:0] REG_T3    = 3'd2;
   localparam logic [2:0] REG_P1    = 3'd3;
   localparam logic [2:0] REG_P2_P3 = 3'd4;
   localparam logic [2:0] REG_P4_P5 = 3'd5;
   localparam logic [2:0] REG_P6_P7 = 3'd6;
   localparam logic [2:0] REG_P8_P9 = 3'd7;

   typedef struct packed {
      logic [19:0] adc_p;
      logic [19:0] adc_t;
      logic        fresh;
   } bpc_item_type;

   typedef struct packed {
      logic [23:0]        pressure_pa;
      logic signed [31:0] temperature_centi;
      logic               fresh;
   } bpc_result_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } bpc_cal_type;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

endpackage
`default_nettype wire

// ----- src/bpc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface bpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] press_msb;
   logic [7:0] press_lsb;
   logic [7:0] press_xlsb;
   logic [7:0] temp_msb;
   logic [7:0] temp_lsb;
   logic [7:0] temp_xlsb;
   logic       read_ok;
   modport source(output valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                  temp_xlsb, read_ok, input ready);
   modport sink(input valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                temp_xlsb, read_ok, output ready);
endinterface

interface bpc_rsp_if;
   logic               valid;
   logic               ready;
   logic [23:0]        pressure_pa;
   logic signed [31:0] temperature_centi;
   logic               fresh;
   modport source(output valid, pressure_pa, temperature_centi, fresh, input ready);
   modport sink(input valid, pressure_pa, temperature_centi, fresh, output ready);
endinterface
`default_nettype wire

// ----- src/bpc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_front (
   input  wire logic          clock,
   input  wire logic          reset,
   bpc_req_if.sink            req_ch,
   output logic               push_valid,
   input  wire logic          push_ready,
   output bpc_pkg::bpc_item_type push_item
);
   import bpc_pkg::*;

   logic [19:0] held_p_ff, held_p_in;
   logic [19:0] held_t_ff, held_t_in;
   logic [19:0] new_p, new_t;

   assign new_p = {req_ch.press_msb, req_ch.press_lsb, req_ch.press_xlsb[7:4]};
   assign new_t = {req_ch.temp_msb, req_ch.temp_lsb, req_ch.temp_xlsb[7:4]};

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;

   // A failed read reuses the last good frame.
   always_comb begin
      push_item.adc_p = req_ch.read_ok ? new_p : held_p_ff;
      push_item.adc_t = req_ch.read_ok ? new_t : held_t_ff;
      push_item.fresh = req_ch.read_ok;
      held_p_in = held_p_ff;
      held_t_in = held_t_ff;
      if (req_ch.valid && push_ready && req_ch.read_ok) begin
         held_p_in = new_p;
         held_t_in = new_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_p_ff <= '0;
         held_t_ff <= '0;
      end else begin
         held_p_ff <= held_p_in;
         held_t_ff <= held_t_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/bpc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  bpc_pkg::bpc_item_type push_item,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output bpc_pkg::bpc_item_type pop_item
);
   import bpc_pkg::*;

   bpc_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/bpc_mul64.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_mul64 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      prod
);
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] ma, mb;
   logic [63:0] m;

   // Product modulo 2^64 from three 32x32 partial products on one multiplier.
   assign ma = (cnt_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
   assign mb = (cnt_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
   assign m  = ma * mb;
   assign done = done_ff;
   assign prod = acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            acc_in = m;
         end else begin
            acc_in = {acc_ff[63:32] + m[31:0], acc_ff[31:0]};
         end
         if (cnt_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/bpc_div64.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_div64 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [63:0]      quo
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] ad_ff, ad_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] rem_sh, diff;

   // Restoring division on magnitudes, one quotient bit per cycle.
   assign rem_sh = {rem_ff, q_ff[63]};
   assign diff   = rem_sh - {1'b0, ad_ff};
   assign done   = done_ff;
   assign quo    = neg_ff ? (64'd0 - q_ff) : q_ff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      ad_in   = ad_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = num[63] ? (64'd0 - num) : num;
         ad_in   = den[63] ? (64'd0 - den) : den;
         neg_in  = num[63] ^ den[63];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ad_ff  <= ad_in;
      neg_ff <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/bpc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   output logic                    item_ready,
   input  bpc_pkg::bpc_item_type   item,
   input  bpc_pkg::bpc_cal_type    cal,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output bpc_pkg::bpc_result_type res
);
   import bpc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_MWAIT = 5'b00100,
      ST_DWAIT = 5'b01000,
      ST_DONE  = 5'b10000
   } bpc_state_type;

   localparam logic [3:0] STEP_TA  = 4'd0;
   localparam logic [3:0] STEP_DD  = 4'd1;
   localparam logic [3:0] STEP_TF  = 4'd2;
   localparam logic [3:0] STEP_SQ  = 4'd3;
   localparam logic [3:0] STEP_P6  = 4'd4;
   localparam logic [3:0] STEP_P5  = 4'd5;
   localparam logic [3:0] STEP_P3  = 4'd6;
   localparam logic [3:0] STEP_P2  = 4'd7;
   localparam logic [3:0] STEP_P1  = 4'd8;
   localparam logic [3:0] STEP_NUM = 4'd9;
   localparam logic [3:0] STEP_H1  = 4'd10;
   localparam logic [3:0] STEP_H2  = 4'd11;
   localparam logic [3:0] STEP_P8  = 4'd12;

   bpc_state_type  state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   logic [19:0]    adc_p_ff, adc_p_in, adc_t_ff, adc_t_in;
   logic           fresh_ff, fresh_in;
   logic [31:0]    ta_ff, ta_in, e_ff, e_in, tf_ff, tf_in;
   logic [63:0]    sq_ff, sq_in, v2_ff, v2_in, w_ff, w_in;
   logic [63:0]    vd_ff, vd_in, p_ff, p_in, x_ff, x_in;
   logic           pz_ff, pz_in;
   logic           res_valid_ff, res_valid_in;
   bpc_result_type res_ff, res_in;

   logic [63:0] op_a, op_b, prod, quo, v1c, h, num0, psum;
   logic [31:0] lo, t5, pq;
   logic [20:0] pdiff;
   logic        mul_start, mul_done, div_start, div_done;

   bpc_mul64 u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(op_a), .op_b(op_b),
      .done(mul_done), .prod(prod)
   );

   bpc_div64 u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(prod), .den(vd_ff),
      .done(div_done), .quo(quo)
   );

   assign lo        = prod[31:0];
   assign v1c       = sx32(tf_ff) - 64'd128000;
   assign h         = asr64(p_ff, 13);
   assign pdiff     = 21'd1048576 - {1'b0, adc_p_ff};
   assign num0      = ({43'd0, pdiff} << 31) - v2_ff;
   assign mul_start = (state_ff == ST_ISSUE);
   assign div_start = (state_ff == ST_MWAIT) && mul_done && (step_ff == STEP_NUM);
   assign item_ready = (state_ff == ST_IDLE);
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   // Final scaling of both results.
   assign t5   = {tf_ff[29:0], 2'b00} + tf_ff + 32'd128;
   assign psum = p_ff + x_ff;
   assign pq   = pz_ff ? 32'd0
                       : (psum[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'b0000});

   always_comb begin
      case (step_ff)
         STEP_TA: begin
            op_a = {32'd0, {15'd0, adc_t_ff[19:3]} - {15'd0, cal.t1, 1'b0}};
            op_b = sx16(cal.t2);
         end
         STEP_DD: begin
            op_a = {32'd0, {16'd0, adc_t_ff[19:4]} - {16'd0, cal.t1}};
            op_b = op_a;
         end
         STEP_TF: begin
            op_a = {32'd0, e_ff};
            op_b = sx16(cal.t3);
         end
         STEP_SQ: begin
            op_a = v1c;
            op_b = v1c;
         end
         STEP_P6: begin
            op_a = sq_ff;
            op_b = sx16(cal.p6);
         end
         STEP_P5: begin
            op_a = v1c;
            op_b = sx16(cal.p5);
         end
         STEP_P3: begin
            op_a = sq_ff;
            op_b = sx16(cal.p3);
         end
         STEP_P2: begin
            op_a = v1c;
            op_b = sx16(cal.p2);
         end
         STEP_P1: begin
            op_a = (64'd1 << 47) + w_ff;
            op_b = {48'd0, cal.p1};
         end
         STEP_NUM: begin
            op_a = num0;
            op_b = 64'd3125;
         end
         STEP_H1: begin
            op_a = sx16(cal.p9);
            op_b = h;
         end
         STEP_H2: begin
            op_a = x_ff;
            op_b = h;
         end
         STEP_P8: begin
            op_a = sx16(cal.p8);
            op_b = p_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      adc_p_in     = adc_p_ff;
      adc_t_in     = adc_t_ff;
      fresh_in     = fresh_ff;
      ta_in        = ta_ff;
      e_in         = e_ff;
      tf_in        = tf_ff;
      sq_in        = sq_ff;
      v2_in        = v2_ff;
      w_in         = w_ff;
      vd_in        = vd_ff;
      p_in         = p_ff;
      x_in         = x_ff;
      pz_in        = pz_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_ready;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               adc_p_in = item.adc_p;
               adc_t_in = item.adc_t;
               fresh_in = item.fresh;
               pz_in    = 1'b0;
               step_in  = STEP_TA;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               step_in  = step_ff + 4'd1;
               state_in = ST_ISSUE;
               case (step_ff)
                  STEP_TA: ta_in = asr32(lo, 11);
                  STEP_DD: e_in = asr32(lo, 12);
                  STEP_TF: tf_in = ta_ff + asr32(lo, 14);
                  STEP_SQ: sq_in = prod;
                  STEP_P6: v2_in = prod;
                  STEP_P5: v2_in = v2_ff + (prod << 17) + (sx16(cal.p4) << 35);
                  STEP_P3: w_in = asr64(prod, 8);
                  STEP_P2: w_in = w_ff + (prod << 12);
                  STEP_P1: begin
                     vd_in = asr64(prod, 33);
                     // A zero divisor forces the pressure to zero.
                     if (asr64(prod, 33) == 64'd0) begin
                        pz_in    = 1'b1;
                        state_in = ST_DONE;
                     end
                  end
                  STEP_NUM: state_in = ST_DWAIT;
                  STEP_H1: x_in = prod;
                  STEP_H2: x_in = asr64(prod, 25);
                  STEP_P8: begin
                     x_in     = x_ff + asr64(prod, 19);
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DWAIT: begin
            if (div_done) begin
               p_in     = quo;
               step_in  = STEP_H1;
               state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (!res_valid_ff || res_ready) begin
               res_in.pressure_pa       = pq[31:8];
               res_in.temperature_centi = $signed(asr32(t5, 8));
               res_in.fresh             = fresh_ff;
               res_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      adc_p_ff <= adc_p_in;
      adc_t_ff <= adc_t_in;
      fresh_ff <= fresh_in;
      ta_ff    <= ta_in;
      e_ff     <= e_in;
      tf_ff    <= tf_in;
      sq_ff    <= sq_in;
      v2_ff    <= v2_in;
      w_ff     <= w_in;
      vd_ff    <= vd_in;
      p_ff     <= p_in;
      x_ff     <= x_in;
      pz_ff    <= pz_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_TA;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         res_valid_ff <= res_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/baro_pressure_temp_compensation_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Barometer compensation: each item on req_ch (a raw six-byte frame and a read-ok flag)
// gives one item on rsp_ch with pressure in pascals, temperature in hundredths of a
// degree and a fresh flag. A failed read reuses the last good raw values. Items enter a
// two-deep queue and are then worked one at a time by a sequencer that shares one 32x32
// multiplier (thirteen 64-bit products, three partial products each) and a radix-2
// divider; a zero divisor skips the divide and the rest of the pressure steps.
// Calibration registers sit at byte address 4*index on the APB port. The user must
// write them only while no item is in flight; the block itself does not enforce this.
module baro_pressure_temp_compensation_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bpc_req_if.sink                              req_ch,
   bpc_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bpc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import bpc_pkg::*;

   logic [15:0] t1_ff, t2_ff, t3_ff, p1_ff;
   logic [31:0] p23_ff, p45_ff, p67_ff, p89_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   bpc_cal_type    cal;
   bpc_item_type   push_item, pop_item;
   bpc_result_type res;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff  <= '0;
         t2_ff  <= '0;
         t3_ff  <= '0;
         p1_ff  <= '0;
         p23_ff <= '0;
         p45_ff <= '0;
         p67_ff <= '0;
         p89_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_T1:    t1_ff  <= csr_pwdata[15:0];
            REG_T2:    t2_ff  <= csr_pwdata[15:0];
            REG_T3:    t3_ff  <= csr_pwdata[15:0];
            REG_P1:    p1_ff  <= csr_pwdata[15:0];
            REG_P2_P3: p23_ff <= csr_pwdata;
            REG_P4_P5: p45_ff <= csr_pwdata;
            REG_P6_P7: p67_ff <= csr_pwdata;
            REG_P8_P9: p89_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_T1:    csr_prdata = {16'd0, t1_ff};
         REG_T2:    csr_prdata = {16'd0, t2_ff};
         REG_T3:    csr_prdata = {16'd0, t3_ff};
         REG_P1:    csr_prdata = {16'd0, p1_ff};
         REG_P2_P3: csr_prdata = p23_ff;
         REG_P4_P5: csr_prdata = p45_ff;
         REG_P6_P7: csr_prdata = p67_ff;
         REG_P8_P9: csr_prdata = p89_ff;
         default:   csr_prdata = '0;
      endcase
   end

   always_comb begin
      cal.t1 = t1_ff;
      cal.t2 = t2_ff;
      cal.t3 = t3_ff;
      cal.p1 = p1_ff;
      cal.p2 = p23_ff[15:0];
      cal.p3 = p23_ff[31:16];
      cal.p4 = p45_ff[15:0];
      cal.p5 = p45_ff[31:16];
      cal.p6 = p67_ff[15:0];
      cal.p7 = p67_ff[31:16];
      cal.p8 = p89_ff[15:0];
      cal.p9 = p89_ff[31:16];
   end

   bpc_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
   );

   bpc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
   );

   bpc_back u_back (
      .clock(clock), .reset(reset),
      .item_valid(pop_valid), .item_ready(pop_ready), .item(pop_item), .cal(cal),
      .res_valid(rsp_ch.valid), .res_ready(rsp_ch.ready), .res(res)
   );

   assign rsp_ch.pressure_pa       = res.pressure_pa;
   assign rsp_ch.temperature_centi = res.temperature_centi;
   assign rsp_ch.fresh             = res.fresh;
endmodule
`default_nettype wire

// ----- src/bpc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_pressure_pa,
   input wire logic [31:0] rsp_temperature_centi,
   input wire logic        rsp_fresh,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [4:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata
);
   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pressure_pa) && $stable(rsp_temperature_centi)
         && $stable(rsp_fresh))
      else $error("result changed while stalled");

   // Nothing comes out right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   // A full-width register reads back what was written to it.
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[4] |=>
         !(csr_psel && !csr_pwrite && csr_paddr[4:2] == $past(csr_paddr[4:2]))
         || csr_prdata == $past(csr_pwdata))
      else $error("register readback mismatch");
endmodule

bind baro_pressure_temp_compensation_top bpc_checker u_bpc_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_pressure_pa(rsp_ch.pressure_pa),
   .rsp_temperature_centi(rsp_ch.temperature_centi),
   .rsp_fresh(rsp_ch.fresh),
   .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
   .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata)
);
`default_nettype wire

// ----- bench/tb_baro_pressure_temp_compensation_top.sv -----
`timescale 1ns / 1ps
module tb_baro_pressure_temp_compensation_top;
   import bpc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bpc_req_if req_ch();
   bpc_rsp_if rsp_ch();

   baro_pressure_temp_compensation_top uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("tb_baro_pressure_temp_compensation_top: FAIL");
      $finish;
   end

   typedef struct {
      logic [23:0] pressure_pa;
      logic [31:0] temperature_centi;
      logic        fresh;
   } reading_type;

   reading_type pending_readings[$];
   logic [31:0] cal_word[8];
   logic [19:0] kept_adc_p, kept_adc_t;
   int          error_count = 0;
   int          idle_pct = 22;
   int          rsp_hold_cycles = 0;

   function automatic logic [31:0] shr32(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] shr64(input logic [63:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] ext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Temperature and pressure compensation in 32- and 64-bit two's complement.
   function automatic reading_type compensate(input logic [19:0] adc_p,
                                              input logic [19:0] adc_t,
                                              input logic ok);
      reading_type r;
      logic [31:0] t1, t2, t3, a, d, b, tf;
      logic [63:0] v1, v2, p, h, an, ad, q, pw;
      t1 = {16'd0, cal_word[REG_T1][15:0]};
      t2 = {{16{cal_word[REG_T2][15]}}, cal_word[REG_T2][15:0]};
      t3 = {{16{cal_word[REG_T3][15]}}, cal_word[REG_T3][15:0]};
      a = shr32(((32'(adc_t) >> 3) - (t1 << 1)) * t2, 11);
      d = (32'(adc_t) >> 4) - t1;
      b = shr32(shr32(d * d, 12) * t3, 14);
      tf = a + b;
      r.temperature_centi = shr32(tf * 32'd5 + 32'd128, 8);
      r.fresh = ok;
      v1 = {{32{tf[31]}}, tf} - 64'd128000;
      v2 = v1 * v1 * ext16(cal_word[REG_P6_P7][15:0]);
      v2 += (v1 * ext16(cal_word[REG_P4_P5][31:16])) << 17;
      v2 += ext16(cal_word[REG_P4_P5][15:0]) << 35;
      v1 = shr64(v1 * v1 * ext16(cal_word[REG_P2_P3][31:16]), 8)
         + ((v1 * ext16(cal_word[REG_P2_P3][15:0])) << 12);
      v1 = shr64(((64'd1 << 47) + v1) * {48'd0, cal_word[REG_P1][15:0]}, 33);
      if (v1 == 0) begin
         r.pressure_pa = '0;
         return r;
      end
      p = 64'd1048576 - 64'(adc_p);
      pw = ((p << 31) - v2) * 64'd3125;
      an = pw[63] ? -pw : pw;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (pw[63] != v1[63]) ? -q : q;
      h = shr64(p, 13);
      v1 = shr64(ext16(cal_word[REG_P8_P9][31:16]) * h * h, 25);
      v2 = shr64(ext16(cal_word[REG_P8_P9][15:0]) * p, 19);
      p = shr64(p + v1 + v2, 8) + (ext16(cal_word[REG_P6_P7][31:16]) << 4);
      r.pressure_pa = p[31:8];
      return r;
   endfunction

   task automatic write_cal(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cal_word[idx] = (idx < REG_P2_P3) ? {16'd0, value[15:0]} : value;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic send_frame(input logic [7:0] pm, pl, px, tm, tl, tx, input logic ok);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.press_msb <= pm; req_ch.press_lsb <= pl; req_ch.press_xlsb <= px;
      req_ch.temp_msb <= tm; req_ch.temp_lsb <= tl; req_ch.temp_xlsb <= tx;
      req_ch.read_ok <= ok;
      do @(posedge clock); while (!req_ch.ready);
      if (ok) begin
         kept_adc_p = {pm, pl, px[7:4]};
         kept_adc_t = {tm, tl, tx[7:4]};
      end
      pending_readings.push_back(compensate(kept_adc_p, kept_adc_t, ok));
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic send_random(input int ok_pct);
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), $urandom_range(99) < ok_pct);
   endtask

   // Typical sensor frames: raw values near the middle of the range.
   task automatic send_plausible();
      logic [19:0] rp, rt;
      logic [3:0] lo1, lo2;
      rp = 20'($urandom_range(200000, 700000));
      rt = 20'($urandom_range(400000, 600000));
      lo1 = 4'($urandom); lo2 = 4'($urandom);
      send_frame(rp[19:12], rp[11:4], {rp[3:0], lo1}, rt[19:12], rt[11:4], {rt[3:0], lo2},
                 $urandom_range(99) < 85);
   endtask

   task automatic wait_drained();
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic load_typical_cal();
      write_cal(REG_T1, 27504);
      write_cal(REG_T2, 26435);
      write_cal(REG_T3, 16'(-1000));
      write_cal(REG_P1, 36477);
      write_cal(REG_P2_P3, {16'd3024, 16'(-10685)});
      write_cal(REG_P4_P5, {16'(-140), 16'd2855});
      write_cal(REG_P6_P7, {16'd15500, 16'(-7)});
      write_cal(REG_P8_P9, {16'd6000, 16'(-14600)});
   endtask

   task automatic load_random_cal();
      for (int i = 0; i < 8; i++) write_cal(3'(i), $urandom);
   endtask

   task automatic test_zero_cal();
      send_frame(8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 1'b1);
      send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      wait_drained();
   endtask

   task automatic test_directed_frames();
      load_typical_cal();
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_frame(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 1'b1);
      send_frame(8'h65, 8'h5A, 8'hCF, 8'h7E, 8'hED, 8'h0F, 1'b1);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(8'hAA, 8'h55, 8'hA5, 8'h55, 8'hAA, 8'h5A, 1'b1);
      send_frame(8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55, 8'hA5, 1'b1);
      send_frame(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 1'b0);
      wait_drained();
      // Extreme calibration words drive the wrapping paths.
      write_cal(REG_T1, 32'h0000FFFF);
      write_cal(REG_T2, 32'h00008000);
      write_cal(REG_T3, 32'h00007FFF);
      write_cal(REG_P1, 32'h0000FFFF);
      write_cal(REG_P2_P3, 32'h7FFF8000);
      write_cal(REG_P4_P5, 32'h80007FFF);
      write_cal(REG_P6_P7, 32'hFFFF7FFF);
      write_cal(REG_P8_P9, 32'h80008000);
      send_frame(8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hF0, 1'b1);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      send_frame(8'h80, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 1'b1);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_typical();
      load_typical_cal();
      for (int i = 0; i < 440; i++) send_plausible();
      wait_drained();
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 600;
      for (int i = 0; i < 8; i++) send_plausible();
      wait_drained();
   endtask

   task automatic test_no_idling();
      idle_pct = 0;
      for (int i = 0; i < 150; i++) send_plausible();
      idle_pct = 22;
      wait_drained();
   endtask

   task automatic test_random_cal();
      for (int k = 0; k < 16; k++) begin
         load_random_cal();
         for (int i = 0; i < 30; i++) begin
            if (i % 3 == 0) send_random(50);
            else send_plausible();
         end
         wait_drained();
      end
      write_cal(REG_P1, 0);
      for (int i = 0; i < 20; i++) send_random(70);
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_pct == 0) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_readings.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_ch.pressure_pa !== want.pressure_pa) begin
               $error("pressure_pa expected %0d got %0d", want.pressure_pa,
                      rsp_ch.pressure_pa);
               error_count++;
            end
            if (rsp_ch.temperature_centi !== want.temperature_centi) begin
               $error("temperature_centi expected %0d got %0d",
                      $signed(want.temperature_centi), rsp_ch.temperature_centi);
               error_count++;
            end
            if (rsp_ch.fresh !== want.fresh) begin
               $error("fresh expected %0b got %0b", want.fresh, rsp_ch.fresh);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.press_msb = '0; req_ch.press_lsb = '0; req_ch.press_xlsb = '0;
      req_ch.temp_msb = '0; req_ch.temp_lsb = '0; req_ch.temp_xlsb = '0;
      req_ch.read_ok = 1'b0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < 8; i++) cal_word[i] = '0;
      kept_adc_p = '0;
      kept_adc_t = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_zero_cal();
      test_directed_frames();
      test_random_typical();
      test_backpressure();
      test_no_idling();
      test_random_cal();
      test_random_typical();
      if (pending_readings.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("tb_baro_pressure_temp_compensation_top: PASS");
      end else begin
         $display("tb_baro_pressure_temp_compensation_top: FAIL");
      end
      $finish;
   end
endmodule
